### rtl/core/htd_pkg.sv
package htd_pkg;

   localparam int NODE_COUNT  = 512;
   localparam int SYMBOL_BITS = 8;
   localparam int INDEX_BITS  = 9;
   localparam int SYMBOL_OUT_BITS = 8;
   localparam int ADDR_BITS   = $clog2(NODE_COUNT);

   localparam logic KIND_NODE_WRITE = 1'b0;
   localparam logic KIND_CODE_BIT   = 1'b1;

   typedef struct packed {
      logic [INDEX_BITS-1:0]  left;
      logic [INDEX_BITS-1:0]  right;
      logic                   leaf;
      logic [SYMBOL_BITS-1:0] sym;
   } node_entry_type;

   typedef enum logic [1:0] {
      REFRESH_IDLE,
      REFRESH_READ,
      REFRESH_LOAD
   } refresh_state_type;

endpackage

### rtl/core/htd_node_ram.sv
module htd_node_ram (
   input  logic                           clock,
   input  logic                           wr_en,
   input  logic [htd_pkg::ADDR_BITS-1:0]  wr_addr,
   input  htd_pkg::node_entry_type        wr_data,
   input  logic                           rd_en,
   input  logic [htd_pkg::ADDR_BITS-1:0]  rd_addr,
   output htd_pkg::node_entry_type        rd_data
);

   htd_pkg::node_entry_type mem [htd_pkg::NODE_COUNT];
   htd_pkg::node_entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/core/huffman_tree_decoder.sv
// Bit-serial code tree walker. Node write requests load one entry of the node table (a
// synchronous RAM of NODE_COUNT entries, one write and one read port) and send the walk
// back to the root. Code bit requests are taken one per cycle: the entry of the current
// node is held in a register, the chosen child is read from the RAM, and in the next cycle
// the child is checked for a leaf; a leaf puts its symbol in the output register and the
// walk returns to the root, whose entry is kept in a shadow register. The RAM read port is
// the one loop in the walk, and its read latency is covered by steering the next
// address straight from the read data. Requests stall only while a finished symbol waits
// behind a full output register, and while the READ and LOAD states fetch the new root
// entry after a root_node write.
module huffman_tree_decoder (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic                                  req_kind,
   input  logic [htd_pkg::INDEX_BITS-1:0]        req_node_index,
   input  logic [htd_pkg::INDEX_BITS-1:0]        req_left_child,
   input  logic [htd_pkg::INDEX_BITS-1:0]        req_right_child,
   input  logic                                  req_is_leaf,
   input  logic [7:0]                            req_leaf_symbol,
   input  logic                                  req_code_bit,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic [htd_pkg::SYMBOL_OUT_BITS-1:0]   rsp_symbol,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [htd_pkg::INDEX_BITS-1:0]        csr_root_node
);

   htd_pkg::refresh_state_type refresh_state_ff, refresh_state_in;
   logic refresh_rd, refresh_load;

   logic [htd_pkg::INDEX_BITS-1:0] root_node_ff, root_node_in;
   htd_pkg::node_entry_type root_entry_ff, root_entry_in;
   htd_pkg::node_entry_type cur_entry_ff, cur_entry_in;

   logic s1_valid_ff, s1_valid_in;
   logic rd_oob_ff, rd_oob_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic [htd_pkg::SYMBOL_OUT_BITS-1:0] rsp_symbol_ff, rsp_symbol_in;

   htd_pkg::node_entry_type mem_rd_data, mem_entry, walk_entry, wr_entry, root_next;
   logic [htd_pkg::INDEX_BITS-1:0] next_node, rd_node;
   logic mem_rd_en, mem_wr_en;
   logic req_fire, bit_fire, write_fire, csr_fire;
   logic s1_leaf, out_free, s1_go, load_rsp, wr_in_range, root_hit;

   // node table
   htd_node_ram u_node_ram (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (htd_pkg::ADDR_BITS'(req_node_index)),
      .wr_data (wr_entry),
      .rd_en   (mem_rd_en),
      .rd_addr (htd_pkg::ADDR_BITS'(rd_node)),
      .rd_data (mem_rd_data)
   );

   // root refresh sequencer
   always_comb begin
      refresh_state_in = refresh_state_ff;
      unique case (refresh_state_ff)
         htd_pkg::REFRESH_IDLE: begin
            if (csr_fire) begin
               refresh_state_in = htd_pkg::REFRESH_READ;
            end
         end
         htd_pkg::REFRESH_READ: refresh_state_in = htd_pkg::REFRESH_LOAD;
         htd_pkg::REFRESH_LOAD: refresh_state_in = htd_pkg::REFRESH_IDLE;
         default:               refresh_state_in = htd_pkg::REFRESH_IDLE;
      endcase
   end

   always_comb begin
      csr_ready    = 1'b0;
      refresh_rd   = 1'b0;
      refresh_load = 1'b0;
      unique case (refresh_state_ff)
         htd_pkg::REFRESH_IDLE: csr_ready    = 1'b1;
         htd_pkg::REFRESH_READ: refresh_rd   = 1'b1;
         htd_pkg::REFRESH_LOAD: refresh_load = 1'b1;
         default:               csr_ready    = 1'b0;
      endcase
   end

   assign csr_fire = csr_valid && csr_ready;

   // walk datapath
   always_comb begin
      mem_entry  = rd_oob_ff ? '0 : mem_rd_data;
      s1_leaf    = s1_valid_ff && mem_entry.leaf;
      out_free   = !rsp_valid_ff || rsp_ready;
      s1_go      = !s1_leaf || out_free;
      req_ready  = (refresh_state_ff == htd_pkg::REFRESH_IDLE) && (!s1_valid_ff || s1_go);
      req_fire   = req_valid && req_ready;
      bit_fire   = req_fire && (req_kind == htd_pkg::KIND_CODE_BIT);
      write_fire = req_fire && (req_kind == htd_pkg::KIND_NODE_WRITE);
      load_rsp   = s1_leaf && out_free;

      if (s1_valid_ff) begin
         walk_entry = mem_entry.leaf ? root_entry_ff : mem_entry;
      end else begin
         walk_entry = cur_entry_ff;
      end
      next_node = req_code_bit ? walk_entry.right : walk_entry.left;
      rd_node   = refresh_rd ? root_node_ff : next_node;
      mem_rd_en = bit_fire || refresh_rd;
      rd_oob_in = (32'(rd_node) >= htd_pkg::NODE_COUNT);

      wr_entry.left  = req_left_child;
      wr_entry.right = req_right_child;
      wr_entry.leaf  = req_is_leaf;
      wr_entry.sym   = htd_pkg::SYMBOL_BITS'(req_leaf_symbol);
      wr_in_range    = (32'(req_node_index) < htd_pkg::NODE_COUNT);
      mem_wr_en      = write_fire && wr_in_range;
      root_hit       = mem_wr_en && (req_node_index == root_node_ff);
      root_next      = root_hit ? wr_entry : root_entry_ff;
   end

   always_comb begin
      root_node_in  = csr_fire ? csr_root_node : root_node_ff;
      root_entry_in = refresh_load ? mem_entry : root_next;

      if (write_fire) begin
         cur_entry_in = root_next;
      end else if (refresh_load) begin
         cur_entry_in = mem_entry;
      end else if (s1_valid_ff && s1_go) begin
         cur_entry_in = walk_entry;
      end else begin
         cur_entry_in = cur_entry_ff;
      end

      if (bit_fire) begin
         s1_valid_in = 1'b1;
      end else if (s1_go) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end

      if (load_rsp) begin
         rsp_valid_in  = 1'b1;
         rsp_symbol_in = htd_pkg::SYMBOL_OUT_BITS'(mem_entry.sym);
      end else begin
         rsp_valid_in  = rsp_valid_ff && !rsp_ready;
         rsp_symbol_in = rsp_symbol_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         refresh_state_ff <= htd_pkg::REFRESH_IDLE;
         root_node_ff     <= '0;
         root_entry_ff    <= '0;
         cur_entry_ff     <= '0;
         s1_valid_ff      <= 1'b0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         refresh_state_ff <= refresh_state_in;
         root_node_ff     <= root_node_in;
         root_entry_ff    <= root_entry_in;
         cur_entry_ff     <= cur_entry_in;
         s1_valid_ff      <= s1_valid_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_symbol_ff <= rsp_symbol_in;
      if (mem_rd_en) begin
         rd_oob_ff <= rd_oob_in;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_symbol = rsp_symbol_ff;

`ifndef SYNTH
   a_leaf_blocked_stalls: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && mem_entry.leaf && rsp_valid_ff && !rsp_ready) |-> !req_ready)
      else $error("request taken while a decoded symbol has nowhere to go");

   a_bit_enters_stage: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_kind == htd_pkg::KIND_CODE_BIT) |=> s1_valid_ff)
      else $error("code bit request lost before the child check");

   a_csr_refresh: assert property (@(posedge clock) disable iff (reset)
      (csr_valid && csr_ready) |-> ##2 (refresh_state_ff == htd_pkg::REFRESH_LOAD))
      else $error("root entry not fetched after root write");

   a_rsp_from_leaf: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(s1_valid_ff))
      else $error("symbol shown without a code bit in flight");
`endif

endmodule

### dv/huffman_tree_decoder_checker.sv
module huffman_tree_decoder_checker (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   input  logic                                req_ready,
   input  logic                                req_kind,
   input  logic [htd_pkg::INDEX_BITS-1:0]      req_node_index,
   input  logic [htd_pkg::INDEX_BITS-1:0]      req_left_child,
   input  logic [htd_pkg::INDEX_BITS-1:0]      req_right_child,
   input  logic                                req_is_leaf,
   input  logic [7:0]                          req_leaf_symbol,
   input  logic                                req_code_bit,
   input  logic                                rsp_valid,
   input  logic                                rsp_ready,
   input  logic [htd_pkg::SYMBOL_OUT_BITS-1:0] rsp_symbol,
   input  logic                                csr_valid,
   input  logic                                csr_ready,
   input  logic [htd_pkg::INDEX_BITS-1:0]      csr_root_node,
   output int                                  fail_count,
   output int                                  pending_symbols
);

   htd_pkg::node_entry_type             node_table [htd_pkg::NODE_COUNT];
   logic [htd_pkg::INDEX_BITS-1:0]      root_index;
   logic [htd_pkg::INDEX_BITS-1:0]      walk_position;
   logic [htd_pkg::INDEX_BITS-1:0]      child_index;
   htd_pkg::node_entry_type             here_entry;
   htd_pkg::node_entry_type             child_entry;
   logic [htd_pkg::SYMBOL_OUT_BITS-1:0] oldest_symbol;
   logic [htd_pkg::SYMBOL_OUT_BITS-1:0] expected_symbols [$];

   always @(posedge clock) begin
      if (reset) begin
         root_index = '0;
         walk_position = '0;
         expected_symbols.delete();
         fail_count = 0;
         foreach (node_table[i]) node_table[i] = '0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_symbols.size() == 0) begin
               $error("symbol: expected none, actual %0h", rsp_symbol);
               fail_count++;
            end else begin
               oldest_symbol = expected_symbols.pop_front();
               if (rsp_symbol !== oldest_symbol) begin
                  $error("symbol: expected %0h, actual %0h", oldest_symbol, rsp_symbol);
                  fail_count++;
               end
            end
         end
         if (csr_valid && csr_ready) begin
            root_index = csr_root_node;
            walk_position = csr_root_node;
         end
         if (req_valid && req_ready) begin
            if (req_kind == htd_pkg::KIND_NODE_WRITE) begin
               node_table[req_node_index] = '{left:  req_left_child,
                                              right: req_right_child,
                                              leaf:  req_is_leaf,
                                              sym:   req_leaf_symbol[htd_pkg::SYMBOL_BITS-1:0]};
               walk_position = root_index;
            end else begin
               here_entry = node_table[walk_position];
               child_index = req_code_bit ? here_entry.right : here_entry.left;
               child_entry = node_table[child_index];
               if (child_entry.leaf) begin
                  expected_symbols = {expected_symbols,
                                      htd_pkg::SYMBOL_OUT_BITS'(child_entry.sym)};
                  walk_position = root_index;
               end else begin
                  walk_position = child_index;
               end
            end
         end
      end
      pending_symbols = expected_symbols.size();
   end

endmodule

### dv/huffman_tree_decoder_tb.sv
module huffman_tree_decoder_tb;

   localparam int WATCHDOG_LIMIT = 1000;
   localparam int TOTAL_ITEMS    = 950;
   localparam int CALM_FROM      = 800;
   localparam int SETTLE_CYCLES  = 8;

   logic                                clock;
   logic                                reset;
   logic                                req_valid;
   logic                                req_ready;
   logic                                req_kind;
   logic [htd_pkg::INDEX_BITS-1:0]      req_node_index;
   logic [htd_pkg::INDEX_BITS-1:0]      req_left_child;
   logic [htd_pkg::INDEX_BITS-1:0]      req_right_child;
   logic                                req_is_leaf;
   logic [7:0]                          req_leaf_symbol;
   logic                                req_code_bit;
   logic                                rsp_valid;
   logic                                rsp_ready;
   logic [htd_pkg::SYMBOL_OUT_BITS-1:0] rsp_symbol;
   logic                                csr_valid;
   logic                                csr_ready;
   logic [htd_pkg::INDEX_BITS-1:0]      csr_root_node;

   int                             fail_count;
   int                             pending_symbols;
   int                             idle_cycles = 0;
   int                             stall_left = 0;
   int                             items_sent = 0;
   bit                             calm = 1'b0;
   bit                             defined [htd_pkg::NODE_COUNT];
   logic [htd_pkg::INDEX_BITS-1:0] defined_list [$];

   huffman_tree_decoder dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_kind        (req_kind),
      .req_node_index  (req_node_index),
      .req_left_child  (req_left_child),
      .req_right_child (req_right_child),
      .req_is_leaf     (req_is_leaf),
      .req_leaf_symbol (req_leaf_symbol),
      .req_code_bit    (req_code_bit),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_symbol      (rsp_symbol),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_root_node   (csr_root_node)
   );

   huffman_tree_decoder_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_kind        (req_kind),
      .req_node_index  (req_node_index),
      .req_left_child  (req_left_child),
      .req_right_child (req_right_child),
      .req_is_leaf     (req_is_leaf),
      .req_leaf_symbol (req_leaf_symbol),
      .req_code_bit    (req_code_bit),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_symbol      (rsp_symbol),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_root_node   (csr_root_node),
      .fail_count      (fail_count),
      .pending_symbols (pending_symbols)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   always @(negedge clock) begin
      if (calm) begin
         rsp_ready <= 1'b1;
         stall_left <= 0;
      end else if (stall_left > 0) begin
         rsp_ready <= 1'b0;
         stall_left <= stall_left - 1;
      end else if ($urandom_range(0, 7) == 0) begin
         rsp_ready <= 1'b0;
         stall_left <= $urandom_range(0, 8);
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("status: fail");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   function automatic logic [htd_pkg::INDEX_BITS-1:0] any_defined();
      return defined_list[$urandom_range(0, defined_list.size() - 1)];
   endfunction

   task automatic send_request(input logic kind,
                               input logic [htd_pkg::INDEX_BITS-1:0] idx, left, right,
                               input logic leaf, input logic [7:0] sym, input logic bit_value);
      if (!calm && $urandom_range(0, 4) == 0) begin
         @(negedge clock) req_valid <= 1'b0;
         repeat ($urandom_range(1, 9)) @(negedge clock);
      end else begin
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_kind <= kind;
      req_node_index <= idx;
      req_left_child <= left;
      req_right_child <= right;
      req_is_leaf <= leaf;
      req_leaf_symbol <= sym;
      req_code_bit <= bit_value;
      do @(posedge clock); while (!req_ready);
      items_sent++;
   endtask

   task automatic write_node(input logic [htd_pkg::INDEX_BITS-1:0] idx, left, right,
                             input logic leaf, input logic [7:0] sym);
      send_request(htd_pkg::KIND_NODE_WRITE, idx, left, right, leaf, sym, 1'($urandom));
      if (!defined[idx]) begin
         defined[idx] = 1'b1;
         defined_list = {defined_list, idx};
      end
   endtask

   task automatic send_bit(input logic bit_value);
      send_request(htd_pkg::KIND_CODE_BIT, htd_pkg::INDEX_BITS'($urandom),
                   htd_pkg::INDEX_BITS'($urandom), htd_pkg::INDEX_BITS'($urandom),
                   1'($urandom), 8'($urandom), bit_value);
   endtask

   // children always point at written entries, so no walk can reach an unwritten one
   task automatic scribble_node();
      logic [htd_pkg::INDEX_BITS-1:0] idx;
      idx = htd_pkg::INDEX_BITS'($urandom);
      write_node(idx, ($urandom_range(0, 7) == 0) ? idx : any_defined(), any_defined(),
                 1'($urandom), 8'($urandom));
   endtask

   task automatic walk(input int count);
      repeat (count) begin
         if ($urandom_range(0, 9) == 0) begin
            scribble_node();
         end else begin
            send_bit(1'($urandom));
         end
      end
   endtask

   // leaves first, then internal nodes joining random pairs of subtrees
   task automatic build_tree(input int leaf_count,
                             output logic [htd_pkg::INDEX_BITS-1:0] root);
      bit                             in_tree [htd_pkg::NODE_COUNT];
      logic [htd_pkg::INDEX_BITS-1:0] forest [$];
      logic [htd_pkg::INDEX_BITS-1:0] idx;
      logic [htd_pkg::INDEX_BITS-1:0] left;
      logic [htd_pkg::INDEX_BITS-1:0] right;
      int                             pick;
      repeat (leaf_count) begin
         do idx = htd_pkg::INDEX_BITS'($urandom); while (in_tree[idx]);
         in_tree[idx] = 1'b1;
         write_node(idx, any_defined(), any_defined(), 1'b1, 8'($urandom));
         forest = {forest, idx};
      end
      while (forest.size() > 1) begin
         pick = $urandom_range(0, forest.size() - 1);
         left = forest[pick];
         forest.delete(pick);
         pick = $urandom_range(0, forest.size() - 1);
         right = forest[pick];
         forest.delete(pick);
         do idx = htd_pkg::INDEX_BITS'($urandom); while (in_tree[idx]);
         in_tree[idx] = 1'b1;
         write_node(idx, left, right, 1'b0, 8'($urandom));
         forest = {forest, idx};
      end
      root = forest[0];
   endtask

   task automatic settle();
      @(negedge clock) req_valid <= 1'b0;
      while (pending_symbols != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_root(input logic [htd_pkg::INDEX_BITS-1:0] value);
      settle();
      csr_valid <= 1'b1;
      csr_root_node <= value;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock) csr_valid <= 1'b0;
   endtask

   initial begin
      logic [htd_pkg::INDEX_BITS-1:0] tree_root;
      reset = 1'b1;
      req_valid = 1'b0;
      req_kind = htd_pkg::KIND_NODE_WRITE;
      req_node_index = '0;
      req_left_child = '0;
      req_right_child = '0;
      req_is_leaf = 1'b0;
      req_leaf_symbol = '0;
      req_code_bit = 1'b0;
      csr_valid = 1'b0;
      csr_root_node = '0;
      repeat (12) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      write_node(9'd511, 9'd511, 9'd511, 1'b1, 8'hff);
      write_node(9'd0, 9'd511, 9'd511, 1'b0, 8'h00);
      send_bit(1'b0);
      send_bit(1'b1);
      write_node(9'd1, 9'd0, 9'd0, 1'b1, 8'h00);
      write_node(9'd2, 9'd1, 9'd511, 1'b0, 8'ha5);
      write_node(9'd0, 9'd2, 9'd1, 1'b0, 8'h5a);
      send_bit(1'b1);
      send_bit(1'b0);
      send_bit(1'b0);
      send_bit(1'b0);
      send_bit(1'b1);
      // node write in the middle of a code returns to the root
      send_bit(1'b0);
      write_node(9'd3, 9'd3, 9'd3, 1'b1, 8'h3c);
      send_bit(1'b1);
      // root that is itself a leaf
      write_root(9'd511);
      send_bit(1'b0);
      write_root(9'd1);
      send_bit(1'b1);
      send_bit(1'b0);
      send_bit(1'b0);
      // rewrite the entry of the current root
      write_node(9'd1, 9'd511, 9'd3, 1'b1, 8'h81);
      send_bit(1'b1);
      write_root(9'd0);

      while (items_sent < TOTAL_ITEMS) begin
         calm = (items_sent >= CALM_FROM) || ($urandom_range(0, 3) == 0);
         build_tree(($urandom_range(0, 9) == 0) ? $urandom_range(9, 24) : $urandom_range(2, 8),
                    tree_root);
         if ($urandom_range(0, 7) == 0) begin
            write_root(any_defined());
         end else begin
            write_root(tree_root);
         end
         walk($urandom_range(15, 50));
      end

      settle();
      repeat (12) @(negedge clock);
      if (fail_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

### sim.f
rtl/core/htd_pkg.sv
rtl/core/htd_node_ram.sv
rtl/core/huffman_tree_decoder.sv
dv/huffman_tree_decoder_checker.sv
dv/huffman_tree_decoder_tb.sv
